/* rtl/core/sdspi_pkg.sv */
`timescale 1ns / 1ps
package sdspi_pkg;

	localparam int CMD_W       = 6;
	localparam int ARG_W       = 32;
	localparam int BYTE_W      = 8;
	localparam int VAL_W       = 16;
	localparam int TMO_W       = 16;
	localparam int BLK_LEN_W   = 10;
	localparam int CFG_IDX_W   = 2;
	localparam int MAX_RES     = 6;
	localparam int RES_CNT_W   = 3;
	localparam int S_TDATA_W   = 48;
	localparam int MAX_BLOCK_BYTES_DEF = 512;

	localparam logic [TMO_W-1:0]     RESP_TMO_RST = 16'd8;
	localparam logic [TMO_W-1:0]     TOK_TMO_RST  = 16'd0;
	localparam logic [BLK_LEN_W-1:0] BLK_LEN_RST  = 10'd512;

	localparam logic [BYTE_W-1:0] BYTE_IDLE   = 8'hff;
	localparam logic [BYTE_W-1:0] BYTE_TOKEN  = 8'hfe;
	localparam logic [1:0]        CMD_START   = 2'b01;

	typedef enum logic [1:0] {
		OP_CMD  = 2'd0,
		OP_READ = 2'd1,
		OP_RX   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		K_TX      = 3'd0,
		K_R1      = 3'd1,
		K_DATA    = 3'd2,
		K_CRC     = 3'd3,
		K_TIMEOUT = 3'd4,
		K_BADTOK  = 3'd5
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESP_TMO = 2'd0,
		REG_TOK_TMO  = 2'd1,
		REG_BLK_LEN  = 2'd2
	} reg_idx_t;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_RESP   = 6'b000010,
		PH_TOKEN  = 6'b000100,
		PH_DATA   = 6'b001000,
		PH_CRC_HI = 6'b010000,
		PH_CRC_LO = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [TMO_W-1:0]     resp_tmo;
		logic [TMO_W-1:0]     tok_tmo;
		logic [BLK_LEN_W-1:0] blk_len;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [CMD_W-1:0]  cmd_index;
		logic [ARG_W-1:0]  argument;
		logic [BYTE_W-1:0] rx_byte;
	} req_t;

	typedef struct packed {
		kind_t            kind;
		logic [VAL_W-1:0] value;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0]      count;
		result_t [MAX_RES-1:0]     item;
	} frame_t;

	// bit-serial crc7 over a 40 bit message, msb first, zero start
	function automatic logic [7:0] crc7_raw(input logic [39:0] msg);
		logic [7:0] c;
		logic       fb;
		c = '0;
		for (int i = 39; i >= 0; i--) begin
			fb = c[7] ^ msg[i];
			c  = {c[6:0], 1'b0};
			if (fb) c = c ^ 8'h12;
		end
		return c;
	endfunction

	// crc is linear: xor of the contribution of each set bit, each folded at elaboration
	function automatic logic [7:0] crc7_frame(input logic [39:0] msg);
		logic [7:0] c;
		c = '0;
		for (int i = 0; i < 40; i++) begin
			if (msg[i]) c = c ^ crc7_raw(40'(1) << i);
		end
		return c | 8'h01;
	endfunction

endpackage

/* rtl/core/sd_spi_command_engine_top.sv */
`timescale 1ns / 1ps
// flow: a taken input beat is held in the input register; the state update then
// loads its results into the result buffer, from which result beats are offered
// throughput: one input beat per cycle while the result buffer is free; an
// issue-command beat fills it with six transmit beats that must drain first
// reset: arst_n clears phase, counters and valid flags and loads register defaults
module sd_spi_command_engine_top
	import sdspi_pkg::*;
#(
	parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // cmd_index, argument, rx_byte, zero pad
	input  logic [1:0]           s_tuser,   // operation
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [VAL_W-1:0]     m_tdata,   // value
	output logic [2:0]           m_tuser,   // kind
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TMO_W-1:0]     cfg_data
);

	cfg_t                 cfg_q;
	req_t                 req_s1;
	logic                 valid_s1;
	frame_t               frame_d;
	result_t [MAX_RES-1:0] buf_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic [RES_CNT_W-1:0] rd_idx_q;
	logic                 take, buf_free, process;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resp_tmo <= RESP_TMO_RST;
			cfg_q.tok_tmo  <= TOK_TMO_RST;
			cfg_q.blk_len  <= BLK_LEN_RST;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_RESP_TMO: cfg_q.resp_tmo <= cfg_data;
				REG_TOK_TMO:  cfg_q.tok_tmo  <= cfg_data;
				REG_BLK_LEN:  cfg_q.blk_len  <= cfg_data[BLK_LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign take     = m_tvalid && m_tready;
	assign buf_free = (cnt_q == '0) || (take && cnt_q == RES_CNT_W'(1));
	assign process  = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.op        <= s_tuser;
			req_s1.cmd_index <= s_tdata[CMD_W-1:0];
			req_s1.argument  <= s_tdata[CMD_W+ARG_W-1:CMD_W];
			req_s1.rx_byte   <= s_tdata[CMD_W+ARG_W+BYTE_W-1:CMD_W+ARG_W];
		end
	end

	sdspi_engine #(
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (process),
		.req   (req_s1),
		.cfg   (cfg_q),
		.frame (frame_d)
	);

	// result buffer drains one beat per cycle while m_tready is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rd_idx_q <= '0;
		end else if (process) begin
			cnt_q    <= frame_d.count;
			rd_idx_q <= '0;
		end else if (take) begin
			cnt_q    <= cnt_q - RES_CNT_W'(1);
			rd_idx_q <= rd_idx_q + RES_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (process) buf_q <= frame_d.item;
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = buf_q[rd_idx_q].value;
	assign m_tuser  = buf_q[rd_idx_q].kind;
	assign m_tlast  = buf_q[rd_idx_q].last;

endmodule

/* rtl/core/sdspi_engine.sv */
`timescale 1ns / 1ps
module sdspi_engine
	import sdspi_pkg::*;
#(
	parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  req_t   req,
	input  cfg_t   cfg,
	output frame_t frame
);

	localparam int ClogMax = $clog2(MAX_BLOCK_BYTES + 1);
	localparam int LenW    = (ClogMax > BLK_LEN_W) ? ClogMax : BLK_LEN_W;

	phase_t               phase_q, phase_d;
	logic [TMO_W-1:0]     wait_q, wait_d, wait_dec;
	logic [BLK_LEN_W-1:0] byte_cnt_q, byte_cnt_d, byte_inc;
	logic [BYTE_W-1:0]    crc_hi_q, crc_hi_d;
	logic [BLK_LEN_W-1:0] eff_len;
	logic [39:0]          msg;
	logic [7:0]           crc7;

	always_comb begin
		if (LenW'(cfg.blk_len) > LenW'(MAX_BLOCK_BYTES)) eff_len = BLK_LEN_W'(MAX_BLOCK_BYTES);
		else eff_len = cfg.blk_len;
	end

	assign msg      = {CMD_START, req.cmd_index, req.argument};
	assign crc7     = crc7_frame(msg);
	assign wait_dec = wait_q - TMO_W'(1);
	assign byte_inc = byte_cnt_q + BLK_LEN_W'(1);

	always_comb begin
		phase_d    = phase_q;
		wait_d     = wait_q;
		byte_cnt_d = byte_cnt_q;
		crc_hi_d   = crc_hi_q;
		frame      = '0;
		case (op_t'(req.op))
			OP_CMD: begin
				if (phase_q == PH_IDLE) begin
					for (int i = 0; i < MAX_RES; i++) begin
						frame.item[i].kind = K_TX;
						frame.item[i].last = 1'b0;
					end
					frame.item[0].value = {8'h00, msg[39:32]};
					frame.item[1].value = {8'h00, msg[31:24]};
					frame.item[2].value = {8'h00, msg[23:16]};
					frame.item[3].value = {8'h00, msg[15:8]};
					frame.item[4].value = {8'h00, msg[7:0]};
					frame.item[5].value = {8'h00, crc7};
					frame.count = RES_CNT_W'(MAX_RES);
					wait_d  = cfg.resp_tmo;
					phase_d = PH_RESP;
				end
			end
			OP_READ: begin
				if (phase_q == PH_IDLE) begin
					wait_d     = cfg.tok_tmo;
					byte_cnt_d = '0;
					phase_d    = PH_TOKEN;
				end
			end
			OP_RX: begin
				case (phase_q)
					PH_RESP: begin
						if (req.rx_byte != BYTE_IDLE) begin
							frame.item[0] = '{kind: K_R1, value: {8'h00, req.rx_byte}, last: 1'b1};
							frame.count   = RES_CNT_W'(1);
							phase_d       = PH_IDLE;
						end else begin
							wait_d = wait_dec;
							if (wait_dec == '0) begin
								frame.item[0] = '{kind: K_R1, value: {8'h00, BYTE_IDLE}, last: 1'b1};
								frame.count   = RES_CNT_W'(1);
								phase_d       = PH_IDLE;
							end
						end
					end
					PH_TOKEN: begin
						if (req.rx_byte == BYTE_IDLE) begin
							// zero timeout waits for ever
							if (wait_q != '0) begin
								wait_d = wait_dec;
								if (wait_dec == '0) begin
									frame.item[0] = '{kind: K_TIMEOUT, value: '0, last: 1'b1};
									frame.count   = RES_CNT_W'(1);
									phase_d       = PH_IDLE;
								end
							end
						end else if (req.rx_byte == BYTE_TOKEN) begin
							byte_cnt_d = '0;
							phase_d    = (eff_len == '0) ? PH_CRC_HI : PH_DATA;
						end else begin
							frame.item[0] = '{kind: K_BADTOK, value: {8'h00, req.rx_byte}, last: 1'b1};
							frame.count   = RES_CNT_W'(1);
							phase_d       = PH_IDLE;
						end
					end
					PH_DATA: begin
						// length may have shrunk below the count already passed
						if (byte_cnt_q >= eff_len) begin
							crc_hi_d = req.rx_byte;
							phase_d  = PH_CRC_LO;
						end else begin
							frame.item[0] = '{kind: K_DATA, value: {8'h00, req.rx_byte}, last: 1'b0};
							frame.count   = RES_CNT_W'(1);
							byte_cnt_d    = byte_inc;
							if (byte_inc >= eff_len) phase_d = PH_CRC_HI;
						end
					end
					PH_CRC_HI: begin
						crc_hi_d = req.rx_byte;
						phase_d  = PH_CRC_LO;
					end
					PH_CRC_LO: begin
						frame.item[0] = '{kind: K_CRC, value: {crc_hi_q, req.rx_byte}, last: 1'b1};
						frame.count   = RES_CNT_W'(1);
						phase_d       = PH_IDLE;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			wait_q     <= '0;
			byte_cnt_q <= '0;
			crc_hi_q   <= '0;
		end else if (en) begin
			phase_q    <= phase_d;
			wait_q     <= wait_d;
			byte_cnt_q <= byte_cnt_d;
			crc_hi_q   <= crc_hi_d;
		end
	end

endmodule
